// ===== rtl/bmc_pkg.sv =====
// Shared constants, types and the character decoder for the bracket mismatch counter.
package bmc_pkg;

  localparam int unsigned STACK_DEPTH = 1024;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned LEVEL_W     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned KIND_W      = 2;

  localparam logic [7:0] CHAR_OPEN_PAREN   = 8'h28;
  localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5B;
  localparam logic [7:0] CHAR_OPEN_CURLY   = 8'h7B;
  localparam logic [7:0] CHAR_OPEN_ANGLE   = 8'h3C;
  localparam logic [7:0] CHAR_CLOSE_PAREN  = 8'h29;
  localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D;
  localparam logic [7:0] CHAR_CLOSE_CURLY  = 8'h7D;
  localparam logic [7:0] CHAR_CLOSE_ANGLE  = 8'h3E;

  typedef enum logic [KIND_W-1:0] {
    KIND_PAREN  = 2'd0,
    KIND_SQUARE = 2'd1,
    KIND_CURLY  = 2'd2,
    KIND_ANGLE  = 2'd3
  } bracket_kind_e;

  typedef struct packed {
    logic          is_open;
    logic          is_close;
    bracket_kind_e kind;
  } char_class_t;

  typedef struct packed {
    logic               impossible;
    logic               stack_overflow;
    logic [COUNT_W-1:0] replace_count;
  } result_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    r.is_open  = 1'b0;
    r.is_close = 1'b0;
    r.kind     = KIND_PAREN;
    case (c)
      CHAR_OPEN_PAREN:   begin r.is_open  = 1'b1; r.kind = KIND_PAREN;  end
      CHAR_OPEN_SQUARE:  begin r.is_open  = 1'b1; r.kind = KIND_SQUARE; end
      CHAR_OPEN_CURLY:   begin r.is_open  = 1'b1; r.kind = KIND_CURLY;  end
      CHAR_OPEN_ANGLE:   begin r.is_open  = 1'b1; r.kind = KIND_ANGLE;  end
      CHAR_CLOSE_PAREN:  begin r.is_close = 1'b1; r.kind = KIND_PAREN;  end
      CHAR_CLOSE_SQUARE: begin r.is_close = 1'b1; r.kind = KIND_SQUARE; end
      CHAR_CLOSE_CURLY:  begin r.is_close = 1'b1; r.kind = KIND_CURLY;  end
      CHAR_CLOSE_ANGLE:  begin r.is_close = 1'b1; r.kind = KIND_ANGLE;  end
      default:           r.kind = KIND_PAREN;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/bmc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module bmc_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bmc_engine.sv =====
// Stack engine: cached top of stack, RAM for deeper entries, counters and flags.
module bmc_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       char_code_i,
  input  logic             last_char_i,
  output bmc_pkg::result_t result_o
);

  localparam logic [bmc_pkg::LEVEL_W-1:0] LevelFull = bmc_pkg::LEVEL_W'(bmc_pkg::STACK_DEPTH);
  localparam logic [bmc_pkg::COUNT_W-1:0] CountMax  = '1;

  logic [bmc_pkg::LEVEL_W-1:0] level_q, level_d;
  logic [bmc_pkg::COUNT_W-1:0] count_q, count_d;
  logic                        failed_q, failed_d;
  logic                        ovf_q, ovf_d;
  bmc_pkg::bracket_kind_e      top_q, top_d;
  logic                        byp_q;
  logic [bmc_pkg::KIND_W-1:0]  byp_data_q;

  logic                        wr_en;
  logic [bmc_pkg::ADDR_W-1:0]  wr_addr;
  logic [bmc_pkg::ADDR_W-1:0]  rd_addr;
  logic [bmc_pkg::KIND_W-1:0]  ram_rdata;
  logic [bmc_pkg::KIND_W-1:0]  below;
  bmc_pkg::char_class_t        cls;
  logic [bmc_pkg::LEVEL_W-1:0] level_upd;
  logic [bmc_pkg::COUNT_W-1:0] count_upd;
  logic                        failed_upd, ovf_upd;
  bmc_pkg::bracket_kind_e      top_upd;

  // The entry just under the top: the RAM holds it, unless it was written last cycle.
  assign below = byp_q ? byp_data_q : ram_rdata;
  assign cls   = bmc_pkg::classify(char_code_i);

  always_comb begin
    level_upd  = level_q;
    count_upd  = count_q;
    failed_upd = failed_q;
    ovf_upd    = ovf_q;
    top_upd    = top_q;
    wr_en      = 1'b0;
    wr_addr    = bmc_pkg::ADDR_W'(level_q - bmc_pkg::LEVEL_W'(1));
    if (fire_i && !failed_q && !ovf_q) begin
      if (cls.is_open) begin
        if (level_q == LevelFull) begin
          ovf_upd = 1'b1;
        end else begin
          // The old top moves into the RAM; the new bracket becomes the cached top.
          wr_en     = (level_q != '0);
          top_upd   = cls.kind;
          level_upd = level_q + bmc_pkg::LEVEL_W'(1);
        end
      end else if (level_q == '0) begin
        failed_upd = 1'b1;
      end else begin
        level_upd = level_q - bmc_pkg::LEVEL_W'(1);
        top_upd   = bmc_pkg::bracket_kind_e'(below);
        if (cls.is_close && (cls.kind != top_q) && (count_q != CountMax)) begin
          count_upd = count_q + bmc_pkg::COUNT_W'(1);
        end
      end
    end

    result_o.impossible     = failed_upd || (level_upd != '0);
    result_o.stack_overflow = ovf_upd;
    result_o.replace_count  = count_upd;

    if (fire_i && last_char_i) begin
      level_d  = '0;
      count_d  = '0;
      failed_d = 1'b0;
      ovf_d    = 1'b0;
    end else begin
      level_d  = level_upd;
      count_d  = count_upd;
      failed_d = failed_upd;
      ovf_d    = ovf_upd;
    end
    top_d = top_upd;
    // Always prefetch the entry under the next top.
    rd_addr = bmc_pkg::ADDR_W'(level_d - bmc_pkg::LEVEL_W'(2));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q  <= '0;
      count_q  <= '0;
      failed_q <= 1'b0;
      ovf_q    <= 1'b0;
      top_q    <= bmc_pkg::KIND_PAREN;
      byp_q    <= 1'b0;
    end else begin
      level_q  <= level_d;
      count_q  <= count_d;
      failed_q <= failed_d;
      ovf_q    <= ovf_d;
      top_q    <= top_d;
      byp_q    <= wr_en;
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= top_q;
  end

  bmc_ram #(
    .WIDTH (bmc_pkg::KIND_W),
    .DEPTH (bmc_pkg::STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (top_q),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LevelFull)
    else $error("stack level beyond depth");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (level_q == LevelFull))
    else $error("overflow flag with stack not full");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && last_char_i) |=> (level_q == '0 && count_q == '0 && !failed_q && !ovf_q))
    else $error("state not cleared after last beat");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fire_i && last_char_i) |=> (count_q >= $past(count_q)))
    else $error("replacement count went down within a sequence");

  a_dead_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (failed_q && !(fire_i && last_char_i)) |=> (level_q == $past(level_q)))
    else $error("stack moved after a failure");
`endif

endmodule

// ===== rtl/bracket_mismatch_counter_core.sv =====
// Top level of the bracket mismatch counter: stream ports, input and result registers.
//
// Usage: characters arrive one per beat on the slave stream, s_axis_tdata carrying the
// byte and s_axis_tlast marking the final character of a sequence. Opening brackets
// push their kind onto a stack of STACK_DEPTH entries; every other byte pops it, and a
// closing bracket of a different kind than the popped entry adds one to a saturating
// replacement count. A pop on an empty stack marks the sequence as failed and a push on a
// full one as overflowed; in both cases the remaining characters are ignored.
// Exactly one result beat leaves on the master stream per sequence, after its last
// character: impossible, stack_overflow and the replacement count. State then clears.
// Throughput: one character per clock cycle unless a last character waits for the result
// register. The top of the stack is cached in a flop and the next entry down is prefetched
// from the stack RAM every cycle, with a bypass of the entry written in the previous cycle,
// so back-to-back pushes and pops never wait. An accepted character waits in the input
// register until it fires; the result of a last one is registered and shown on m_axis.
// Reset clears all control state; the stack RAM needs no clearing, since only entries
// written within the current sequence are ever read.
// When the receiver stalls, characters that are not last keep flowing; only a last
// character waits in the input register until the result register is free.
module bracket_mismatch_counter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,   // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [0] impossible, [1] stack_overflow,
                                      // [17:2] replace_count, [23:18] zero
);

  logic             in_valid_q;
  logic [7:0]       in_char_q;
  logic             in_last_q;
  logic             out_valid_q;
  bmc_pkg::result_t out_q;
  bmc_pkg::result_t result;
  logic             fire;
  logic             s_accept;

  // The held beat advances unless it is last and the result register is still occupied.
  assign fire          = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (fire && in_last_q) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (fire && in_last_q) begin
      out_q <= result;
    end
  end

  bmc_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .char_code_i (in_char_q),
    .last_char_i (in_last_q),
    .result_o    (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.replace_count, out_q.stack_overflow, out_q.impossible};

endmodule
